// File: rtl/grc_pkg.sv
`default_nettype none
package grc_pkg;

    localparam int POS_W = 22;
    localparam int ANG_W = 16;
    localparam int COL_W = 11;
    localparam int IDX_W = 12;
    localparam int CFG_IDX_W = 2;

    localparam int MAP_SIDE_DEF = 64;
    localparam int HALF_WIDTH_DEF = 640;
    localparam int FRAC_BITS_DEF = 16;

    // shared rotator: 16 steps, wide enough for a 2^27 start vector times the gain
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 4;
    localparam int CORDIC_W = 31;
    localparam int CORDIC_ZW = 18;
    localparam int ATAN_SCALE = 16;
    localparam int ROT_START_SHIFT = 20;
    // cos and sin after rotation stay below 2^21
    localparam int TRIG_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING = 2'd2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST = 1'b1;

    localparam logic [1:0] SIDE_WEST = 2'd0;
    localparam logic [1:0] SIDE_EAST = 2'd1;
    localparam logic [1:0] SIDE_NORTH = 2'd2;
    localparam logic [1:0] SIDE_SOUTH = 2'd3;

    localparam logic [POS_W-1:0] PLAYER_POS_RESET = 22'd98304;
    localparam logic [ANG_W-1:0] HEADING_RESET = 16'd0;

    localparam logic [ANG_W-1:0] EIGHTH_TURN = 16'h2000;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [ANG_W-1:0] HALF_TURN = 16'h8000;
    localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 16'hC000;

    typedef struct packed {
        logic             mode;
        logic [COL_W-1:0] column;
        logic [IDX_W-1:0] cell_index;
        logic             cell_is_wall;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] wall_side;
        logic [6:0] wall_position;
        logic [5:0] wall_offset;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_cmd;

    // atan(2^-i) in 1/65536 turn
    function automatic logic [13:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [13:0] v;
        unique case (i)
            4'd0:  v = 14'd8192;
            4'd1:  v = 14'd4836;
            4'd2:  v = 14'd2555;
            4'd3:  v = 14'd1297;
            4'd4:  v = 14'd651;
            4'd5:  v = 14'd326;
            4'd6:  v = 14'd163;
            4'd7:  v = 14'd81;
            4'd8:  v = 14'd41;
            4'd9:  v = 14'd20;
            4'd10: v = 14'd10;
            4'd11: v = 14'd5;
            4'd12: v = 14'd3;
            4'd13: v = 14'd1;
            4'd14: v = 14'd1;
            4'd15: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/grc_ram.sv
`default_nettype none
module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/grc_cordic.sv
`default_nettype none
module grc_cordic #(
    parameter int W = grc_pkg::CORDIC_W,
    parameter int ZW = grc_pkg::CORDIC_ZW
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire grc_pkg::t_cordic_cmd  i_cmd,
    input  wire logic signed [W-1:0]   i_x0,
    input  wire logic signed [W-1:0]   i_y0,
    input  wire logic signed [ZW-1:0]  i_z0,
    output logic signed [W-1:0]        o_x,
    output logic signed [W-1:0]        o_y,
    output logic signed [ZW-1:0]       o_z,
    output logic                       o_done
);

    logic signed [W-1:0]  r_x, r_y, n_x, n_y, xs, ys;
    logic signed [ZW-1:0] r_z, n_z, tz;
    logic [grc_pkg::STEP_W-1:0] r_step;
    logic r_vec, r_busy, r_done, rot_pos;

    always_comb begin
        xs = r_x >>> r_step;
        ys = r_y >>> r_step;
        tz = ZW'(grc_pkg::atan_turn(r_step));
        // vectoring drives y toward zero, rotation drives z toward zero
        rot_pos = r_vec ? r_y[W-1] : !r_z[ZW-1];
        if (rot_pos) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - tz;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + tz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == grc_pkg::STEP_W'(grc_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x0;
            r_y   <= i_y0;
            r_z   <= i_z0;
            r_vec <= i_cmd.vectoring;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_done = r_done;

endmodule
`default_nettype wire

// File: rtl/grc_div.sv
`default_nettype none
module grc_div #(
    parameter int NW = 49,
    parameter int DW = grc_pkg::TRIG_W
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic signed [DW-1:0] i_den,
    output logic signed [NW:0]        o_quo,
    output logic                      o_done
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0] r_q, num_mag;
    logic [DW-1:0] r_rem, r_den, den_mag;
    logic [DW:0]   trial, diff;
    logic [NW:0]   q_ext;
    logic [CNT_W-1:0] r_cnt;
    logic r_neg, r_busy, r_fin, r_done;
    logic signed [NW:0] r_quo;

    always_comb begin
        num_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        trial = {r_rem, r_q[NW-1]};
        diff = trial - {1'b0, r_den};
        q_ext = {1'b0, r_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= num_mag;
            r_den <= den_mag;
            r_rem <= '0;
            r_neg <= i_num[NW-1] ^ i_den[DW-1];
        end else if (r_busy) begin
            if (!diff[DW]) begin
                r_rem <= diff[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= trial[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end else if (r_fin) begin
            // round toward minus infinity
            if (r_neg && (r_rem != '0)) begin
                r_quo <= $signed(~q_ext);
            end else if (r_neg) begin
                r_quo <= $signed(-q_ext);
            end else begin
                r_quo <= $signed(q_ext);
            end
        end
    end

    assign o_quo = r_quo;
    assign o_done = r_done;

endmodule
`default_nettype wire

// File: rtl/grid_ray_caster.sv
// Grid ray caster: wall map of MAP_SIDE x MAP_SIDE one-bit cells plus a ray walker.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): mode 0 beats write one
// map cell in the accept cycle and give no result; mode 1 beats cast the ray of one
// screen column and give exactly one result beat.
// Output channel (o_out_valid / i_out_stall, payload o_out_data) is a register: a
// result waits there while the receiver stalls, and the caster may already take
// and work on the next beat; it holds in its last state only while that register
// is still full.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 player x,
// 1 player y, 2 heading; write only while no cast is in flight.
// A cast first finds the angle and then cos/sin on the shared CORDIC, restarting it
// in between; then, per map row crossed, the serial divider finds the x intercept
// (not used for a flat ray), and each cell visited takes a map read; last the
// result is loaded.
// Reset clears control state and loads the player registers; the map contents are
// undefined until loaded and must be loaded before casting.
`default_nettype none
module grid_ray_caster #(
    parameter int MAP_SIDE = grc_pkg::MAP_SIDE_DEF,
    parameter int HALF_WIDTH = grc_pkg::HALF_WIDTH_DEF,
    parameter int FRAC_BITS = grc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire grc_pkg::t_in_beat                  i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output grc_pkg::t_out_beat                      o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [grc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [grc_pkg::POS_W-1:0]          i_cfg_data
);

    localparam int PW = grc_pkg::POS_W;
    localparam int AGW = grc_pkg::ANG_W;
    localparam int XW = grc_pkg::CORDIC_W;
    localparam int ZW = grc_pkg::CORDIC_ZW;
    localparam int CW = grc_pkg::TRIG_W;
    localparam int CELLS = MAP_SIDE * MAP_SIDE;
    localparam int AW = $clog2(CELLS);
    localparam int IW = (PW > FRAC_BITS) ? PW - FRAC_BITS : 1;
    localparam int MSW = $clog2(MAP_SIDE + 1);
    localparam int GW0 = ((IW > MSW) ? IW : MSW) + 2;
    localparam int GW = (GW0 < 8) ? 8 : GW0;
    localparam int DDW = (((GW + FRAC_BITS) > (PW + 1)) ? GW + FRAC_BITS : PW + 1) + 1;
    localparam int PRW = DDW + CW;
    localparam int XQW = PRW + 2;

    localparam logic signed [GW-1:0] G_SIDE = GW'(MAP_SIDE);
    localparam logic signed [GW-1:0] G_NEG1 = {GW{1'b1}};
    localparam logic signed [GW-1:0] G_ONE = GW'(1);
    localparam logic signed [XQW-1:0] X_SIDE = XQW'(MAP_SIDE);
    localparam logic signed [XQW-1:0] X_NEG1 = {XQW{1'b1}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ATAN  = 4'd1;
    localparam logic [3:0] S_ROTS  = 4'd2;
    localparam logic [3:0] S_ROT   = 4'd3;
    localparam logic [3:0] S_ROW   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIVS  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_TGT   = 4'd8;
    localparam logic [3:0] S_XSTEP = 4'd9;
    localparam logic [3:0] S_XCHK  = 4'd10;
    localparam logic [3:0] S_YCHK  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] r_state;
    logic [PW-1:0] r_px, r_py;
    logic [AGW-1:0] r_head, r_ang;
    logic r_out_valid;
    grc_pkg::t_out_beat r_out, r_res;

    logic signed [CW-1:0] r_c, c_val, s_val;
    logic r_dxp, r_dyp, r_flat;
    logic signed [GW-1:0] r_gx, r_gy, r_tgt;
    logic signed [DDW-1:0] r_ddy, ddy;
    logic signed [PRW-1:0] r_prod;
    logic signed [XQW-1:0] r_xq, xq_sh;

    logic in_accept, out_free, ram_we, blocks, x_more;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [0:0] ram_rdata;

    grc_pkg::t_cordic_cmd cordic_cmd;
    logic signed [XW-1:0] cx0, cy0, cx, cy, dxs, y_hw;
    logic signed [ZW-1:0] cz0, cz;
    logic cordic_done;
    logic [1:0] quad;
    logic [AGW-1:0] ang_plus, zr;

    logic div_start, div_done;
    logic signed [PRW:0] div_quo;

    logic signed [GW-1:0] step_x, step_y, nx, ny, yb, cand, tgt_fix, rd_row, rd_col;
    logic signed [GW-1:0] gx_up, gy_up;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    // map write port straight from the input beat
    assign ram_we = in_accept && (i_in_data.mode == grc_pkg::MODE_WRITE)
                    && ({20'd0, i_in_data.cell_index} < 32'(CELLS));
    assign ram_waddr = AW'(i_in_data.cell_index);

    always_comb begin
        step_x = r_dxp ? G_ONE : G_NEG1;
        step_y = r_dyp ? G_ONE : G_NEG1;
        nx = r_gx + step_x;
        ny = r_gy + step_y;
        // far boundary of the current cell, for faces hit while stepping back
        gx_up = r_gx + G_ONE;
        gy_up = r_gy + G_ONE;
        x_more = (r_gx != r_tgt);
        rd_row = x_more ? r_gy : ny;
        rd_col = x_more ? nx : r_gx;
        ram_raddr = AW'(int'(rd_row) * MAP_SIDE + int'(rd_col));
        blocks = (r_gx < 0) || (r_gy < 0) || (r_gx >= G_SIDE) || (r_gy >= G_SIDE)
                 || ram_rdata[0];

        yb = r_dyp ? r_gy + G_ONE : r_gy;
        ddy = (DDW'(yb) <<< FRAC_BITS) - $signed(DDW'(r_py));

        xq_sh = r_xq >>> FRAC_BITS;
        if (r_state == S_ROW) begin
            cand = r_dxp ? G_SIDE : G_NEG1;
        end else if (xq_sh < X_NEG1) begin
            cand = G_NEG1;
        end else if (xq_sh > X_SIDE) begin
            cand = G_SIDE;
        end else begin
            cand = GW'(xq_sh);
        end
        // an intercept behind the current column means no x steps in this row
        if (r_dxp && (cand < r_gx)) begin
            tgt_fix = r_gx;
        end else if (!r_dxp && (cand > r_gx)) begin
            tgt_fix = r_gx;
        end else begin
            tgt_fix = cand;
        end
    end

    always_comb begin
        dxs = (XW'(i_in_data.column) - XW'(HALF_WIDTH)) <<< grc_pkg::ATAN_SCALE;
        y_hw = XW'(HALF_WIDTH) <<< grc_pkg::ATAN_SCALE;
        ang_plus = r_ang + grc_pkg::EIGHTH_TURN;
        quad = ang_plus[AGW-1:AGW-2];
        zr = {r_ang[AGW-1:AGW-2] - quad, r_ang[AGW-3:0]};
        cordic_cmd.start = (r_state == S_ROTS)
                           || (in_accept && (i_in_data.mode == grc_pkg::MODE_CAST));
        cordic_cmd.vectoring = (r_state == S_IDLE);
        if (r_state == S_IDLE) begin
            // left half of the screen: pre-rotate by a quarter turn
            if (dxs[XW-1]) begin
                cx0 = y_hw;
                cy0 = -dxs;
                cz0 = ZW'(grc_pkg::QUARTER_TURN);
            end else begin
                cx0 = dxs;
                cy0 = y_hw;
                cz0 = '0;
            end
        end else begin
            cx0 = XW'(1) <<< grc_pkg::ROT_START_SHIFT;
            cy0 = '0;
            cz0 = ZW'($signed(zr));
        end
        unique case (quad)
            2'd0: begin
                c_val = CW'(cx);
                s_val = CW'(cy);
            end
            2'd1: begin
                c_val = CW'(-cy);
                s_val = CW'(cx);
            end
            2'd2: begin
                c_val = CW'(-cx);
                s_val = CW'(-cy);
            end
            2'd3: begin
                c_val = CW'(cy);
                s_val = CW'(-cx);
            end
        endcase
    end

    assign div_start = (r_state == S_DIVS);

    grc_ram #(
        .WIDTH(1),
        .DEPTH(CELLS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in_data.cell_is_wall),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    grc_cordic #(
        .W (XW),
        .ZW(ZW)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cordic_cmd),
        .i_x0   (cx0),
        .i_y0   (cy0),
        .i_z0   (cz0),
        .o_x    (cx),
        .o_y    (cy),
        .o_z    (cz),
        .o_done (cordic_done)
    );

    grc_div #(
        .NW(PRW),
        .DW(CW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_prod),
        .i_den  (s_val),
        .o_quo  (div_quo),
        .o_done (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_px        <= grc_pkg::PLAYER_POS_RESET;
            r_py        <= grc_pkg::PLAYER_POS_RESET;
            r_head      <= grc_pkg::HEADING_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    grc_pkg::CFG_PLAYER_X: r_px <= i_cfg_data;
                    grc_pkg::CFG_PLAYER_Y: r_py <= i_cfg_data;
                    grc_pkg::CFG_HEADING:  r_head <= i_cfg_data[AGW-1:0];
                    default: ;
                endcase
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_in_data.mode == grc_pkg::MODE_CAST)) begin
                        r_state <= S_ATAN;
                    end
                end
                S_ATAN: begin
                    if (cordic_done) begin
                        r_ang   <= r_head + cz[AGW-1:0];
                        r_state <= S_ROTS;
                    end
                end
                S_ROTS: r_state <= S_ROT;
                S_ROT: begin
                    if (cordic_done) begin
                        r_c    <= c_val;
                        r_dxp  <= (r_ang < grc_pkg::QUARTER_TURN)
                                  || (r_ang > grc_pkg::THREE_QUARTER_TURN);
                        r_dyp  <= (r_ang < grc_pkg::HALF_TURN);
                        r_flat <= (r_ang[AGW-2:0] == '0) || (s_val == '0);
                        r_gx   <= GW'(r_px >> FRAC_BITS);
                        r_gy   <= GW'(r_py >> FRAC_BITS);
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (r_flat) begin
                        r_tgt   <= tgt_fix;
                        r_state <= S_XSTEP;
                    end else begin
                        r_ddy   <= ddy;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_ddy * r_c;
                    r_state <= S_DIVS;
                end
                S_DIVS: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_xq    <= $signed(XQW'(r_px)) + XQW'(div_quo);
                        r_state <= S_TGT;
                    end
                end
                S_TGT: begin
                    r_tgt   <= tgt_fix;
                    r_state <= S_XSTEP;
                end
                S_XSTEP: begin
                    if (x_more) begin
                        r_gx    <= nx;
                        r_state <= S_XCHK;
                    end else begin
                        r_gy    <= ny;
                        r_state <= S_YCHK;
                    end
                end
                S_XCHK: begin
                    if (blocks) begin
                        r_res.wall_side     <= r_dxp ? grc_pkg::SIDE_WEST
                                                     : grc_pkg::SIDE_EAST;
                        r_res.wall_position <= r_dxp ? r_gx[6:0] : gx_up[6:0];
                        r_res.wall_offset   <= r_gy[5:0];
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_XSTEP;
                    end
                end
                S_YCHK: begin
                    if (blocks) begin
                        r_res.wall_side     <= r_dyp ? grc_pkg::SIDE_NORTH
                                                     : grc_pkg::SIDE_SOUTH;
                        r_res.wall_position <= r_dyp ? r_gy[6:0] : gy_up[6:0];
                        r_res.wall_offset   <= r_gx[5:0];
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ROW;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
